/* hw/rtl/hftp_pkg.sv */
// ----------------------------------------------------------------------------
// Heater and fan control package
// Shared widths, codes, word types and defaults for the heater and fan
// time-proportioning controller.
// ----------------------------------------------------------------------------
package hftp_pkg;

  localparam int unsigned OpW      = 3;
  localparam int unsigned ValueW   = 8;
  localparam int unsigned LevelW   = 7;
  localparam int unsigned CycleMsW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = CycleMsW;

  localparam int unsigned FullLevel = 100;
  localparam int unsigned CycleMsMax = (2 ** CycleMsW) - 1;

  localparam int unsigned SliceMsDef        = 100;
  localparam int unsigned MaxCycleSlicesDef = 600;

  localparam logic [CycleMsW-1:0] CycleMsRst       = CycleMsW'(2000);
  localparam logic [LevelW-1:0]   MinHeatLevelRst  = LevelW'(0);
  localparam logic [LevelW-1:0]   MinFanLevelRst   = LevelW'(0);
  localparam logic [LevelW-1:0]   MinFanForHeatRst = LevelW'(50);

  typedef enum logic [OpW-1:0] {
    OP_TICK       = 3'd0,
    OP_SET_HEAT   = 3'd1,
    OP_SET_FAN    = 3'd2,
    OP_START_ROAST = 3'd3,
    OP_START_COOL = 3'd4,
    OP_STOP       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABOVE_MAX = 2'd1,
    ST_BELOW_MIN = 2'd2,
    ST_FAN_LOW   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CYCLE_MS      = 2'd0,
    REG_MIN_HEAT      = 2'd1,
    REG_MIN_FAN       = 2'd2,
    REG_MIN_FAN_HEAT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              heater_drive;
    logic              fan_power;
    logic [LevelW-1:0] fan_drive_level;
    logic [LevelW-1:0] heat_now;
    logic [LevelW-1:0] fan_now;
    logic              fan_auto_raised;
  } out_t;

  typedef struct packed {
    logic [CycleMsW-1:0] period_ms;
    logic [LevelW-1:0]   heat_floor;
    logic [LevelW-1:0]   fan_floor;
    logic [LevelW-1:0]   min_fan_for_heat;
  } cfg_t;

  // Width of the phase accumulator, which holds the cycle length times the
  // level plus the rounding offset, or the saturation cap, whichever is larger.
  function automatic int unsigned acc_width(int unsigned slice_ms, int unsigned max_slices);
    int unsigned bound;
    bound = CycleMsMax * FullLevel + FullLevel * slice_ms
          + FullLevel * slice_ms * max_slices + 1;
    return $clog2(bound);
  endfunction

endpackage

/* hw/rtl/hftp_stream_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface hftp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/hftp_phase_len.sv */
// ----------------------------------------------------------------------------
// Phase length unit
// Works out the on and off phase lengths for one heat level, as scaled
// accumulator values: a phase of n slices is held as a value whose quotient
// by one slice step is n.
// ----------------------------------------------------------------------------
module hftp_phase_len #(
  parameter int unsigned SLICE_MS         = hftp_pkg::SliceMsDef,
  parameter int unsigned MAX_CYCLE_SLICES = hftp_pkg::MaxCycleSlicesDef,
  parameter int unsigned ACC_W            = hftp_pkg::acc_width(SLICE_MS, MAX_CYCLE_SLICES)
) (
  input  logic [hftp_pkg::CycleMsW-1:0] period_ms_i,
  input  logic [hftp_pkg::LevelW-1:0]   level_i,
  output logic [ACC_W-1:0]              on_acc_o,
  output logic                          on_nz_o,
  output logic [ACC_W-1:0]              off_acc_o,
  output logic                          off_nz_o
);
  import hftp_pkg::*;

  // The two roundings (ms then slices) fold into one floor division by the
  // slice step after adding this offset.
  localparam int unsigned StepVal   = FullLevel * SLICE_MS;
  localparam int unsigned OffsetVal = FullLevel * (SLICE_MS - 1);
  localparam int unsigned CapVal    = MAX_CYCLE_SLICES * StepVal + StepVal - 1;

  localparam logic [ACC_W-1:0] Step   = ACC_W'(StepVal);
  localparam logic [ACC_W-1:0] Offset = ACC_W'(OffsetVal);
  localparam logic [ACC_W-1:0] Cap    = ACC_W'(CapVal);

  logic [LevelW-1:0] off_level;
  logic [ACC_W-1:0]  on_sum;
  logic [ACC_W-1:0]  off_sum;

  assign off_level = LevelW'(FullLevel) - level_i;

  assign on_sum  = ACC_W'(period_ms_i) * ACC_W'(level_i) + Offset;
  assign off_sum = ACC_W'(period_ms_i) * ACC_W'(off_level) + Offset;

  assign on_acc_o  = (on_sum > Cap) ? Cap : on_sum;
  assign off_acc_o = (off_sum > Cap) ? Cap : off_sum;
  assign on_nz_o   = (on_sum >= Step);
  assign off_nz_o  = (off_sum >= Step);

endmodule

/* hw/rtl/hftp_core.sv */
// ----------------------------------------------------------------------------
// Heater and fan control core
// Holds the levels, the interlock state and the heater proportioning phase,
// and works out the result of one word in a single step.
// ----------------------------------------------------------------------------
module hftp_core #(
  parameter int unsigned SLICE_MS         = hftp_pkg::SliceMsDef,
  parameter int unsigned MAX_CYCLE_SLICES = hftp_pkg::MaxCycleSlicesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  hftp_pkg::in_t  item_i,
  input  hftp_pkg::cfg_t cfg_i,
  output hftp_pkg::out_t result_o
);
  import hftp_pkg::*;

  localparam int unsigned AccW = acc_width(SLICE_MS, MAX_CYCLE_SLICES);
  localparam logic [AccW-1:0] Step = AccW'(FullLevel * SLICE_MS);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_e;

  logic [LevelW-1:0] heat_q, heat_d;
  logic [LevelW-1:0] fan_q, fan_d;
  logic [LevelW-1:0] sampled_q, sampled_d;
  phase_e            phase_q, phase_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic              pin_q, pin_d;
  logic              dim_on_q, dim_on_d;
  logic [LevelW-1:0] dim_lvl_q, dim_lvl_d;

  logic [LevelW-1:0] lvl_in;
  logic [AccW-1:0]   on_acc, off_acc, acc_dec;
  logic              on_nz, off_nz;
  logic              do_enter, go_on;
  logic [1:0]        status_d;
  logic [1:0]        fan_chk;
  logic              raised_d;
  logic [ValueW-1:0] fan_req;

  // A heat command enters its new level straight into the phase it starts.
  assign lvl_in = (item_i.operation == OP_SET_HEAT) ? item_i.value[LevelW-1:0] : heat_q;

  hftp_phase_len #(
    .SLICE_MS         (SLICE_MS),
    .MAX_CYCLE_SLICES (MAX_CYCLE_SLICES),
    .ACC_W            (AccW)
  ) u_phase_len (
    .period_ms_i (cfg_i.period_ms),
    .level_i     (lvl_in),
    .on_acc_o    (on_acc),
    .on_nz_o     (on_nz),
    .off_acc_o   (off_acc),
    .off_nz_o    (off_nz)
  );

  assign acc_dec = (acc_q >= Step) ? (acc_q - Step) : acc_q;

  // The fan request is either the command value or the heating minimum.
  assign fan_req = (item_i.operation == OP_SET_HEAT) ? ValueW'(cfg_i.min_fan_for_heat)
                                                     : item_i.value;

  always_comb begin
    if (fan_req > ValueW'(FullLevel)) begin
      fan_chk = ST_ABOVE_MAX;
    end else if ((heat_q != '0) && (fan_req < ValueW'(cfg_i.min_fan_for_heat))) begin
      fan_chk = ST_FAN_LOW;
    end else if (fan_req < ValueW'(cfg_i.fan_floor)) begin
      fan_chk = ST_BELOW_MIN;
    end else begin
      fan_chk = ST_OK;
    end
  end

  always_comb begin
    heat_d    = heat_q;
    fan_d     = fan_q;
    sampled_d = sampled_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    pin_d     = pin_q;
    dim_on_d  = dim_on_q;
    dim_lvl_d = dim_lvl_q;
    status_d  = ST_OK;
    raised_d  = 1'b0;
    do_enter  = 1'b0;
    go_on     = 1'b1;

    case (item_i.operation)
      OP_TICK: begin
        if (phase_q != PH_IDLE) begin
          acc_d = acc_dec;
          if ((acc_dec < Step) || (heat_q != sampled_q)) begin
            do_enter = 1'b1;
            go_on    = (phase_q != PH_ON);
          end
        end
      end
      OP_SET_HEAT: begin
        if (item_i.value > ValueW'(FullLevel)) begin
          status_d = ST_ABOVE_MAX;
        end else if (item_i.value < ValueW'(cfg_i.heat_floor)) begin
          status_d = ST_BELOW_MIN;
        end else begin
          if ((item_i.value != '0) && (fan_q < cfg_i.min_fan_for_heat) &&
              (fan_chk == ST_OK)) begin
            raised_d = 1'b1;
            fan_d    = fan_req[LevelW-1:0];
            if (fan_req == '0) begin
              dim_on_d = 1'b0;
            end else begin
              dim_on_d  = 1'b1;
              dim_lvl_d = fan_req[LevelW-1:0];
            end
          end
          heat_d   = item_i.value[LevelW-1:0];
          do_enter = (phase_q == PH_IDLE);
        end
      end
      OP_SET_FAN: begin
        status_d = fan_chk;
        if (fan_chk == ST_OK) begin
          fan_d = fan_req[LevelW-1:0];
          if (fan_req == '0) begin
            dim_on_d = 1'b0;
          end else begin
            dim_on_d  = 1'b1;
            dim_lvl_d = fan_req[LevelW-1:0];
          end
        end
      end
      OP_START_ROAST: begin
        heat_d = '0;
        fan_d  = '0;
      end
      OP_START_COOL: begin
        heat_d    = '0;
        fan_d     = LevelW'(FullLevel);
        dim_lvl_d = LevelW'(FullLevel);
      end
      OP_STOP: begin
        heat_d    = '0;
        fan_d     = '0;
        pin_d     = 1'b0;
        dim_on_d  = 1'b0;
        dim_lvl_d = '0;
      end
      default: begin
      end
    endcase

    // Phase entry: take the wanted phase if it has any length, else the other
    // one; with both empty the off phase is held for one slice.
    if (do_enter) begin
      sampled_d = lvl_in;
      if (go_on ? on_nz : off_nz) begin
        pin_d   = go_on;
        phase_d = go_on ? PH_ON : PH_OFF;
        acc_d   = go_on ? on_acc : off_acc;
      end else if (go_on ? off_nz : on_nz) begin
        pin_d   = !go_on;
        phase_d = go_on ? PH_OFF : PH_ON;
        acc_d   = go_on ? off_acc : on_acc;
      end else begin
        phase_d = PH_OFF;
        acc_d   = Step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q    <= '0;
      fan_q     <= '0;
      sampled_q <= '0;
      phase_q   <= PH_IDLE;
      acc_q     <= '0;
      pin_q     <= 1'b0;
      dim_on_q  <= 1'b0;
      dim_lvl_q <= '0;
    end else if (step_i) begin
      heat_q    <= heat_d;
      fan_q     <= fan_d;
      sampled_q <= sampled_d;
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      pin_q     <= pin_d;
      dim_on_q  <= dim_on_d;
      dim_lvl_q <= dim_lvl_d;
    end
  end

  assign result_o.status          = status_d;
  assign result_o.heater_drive    = pin_d;
  assign result_o.fan_power       = dim_on_d;
  assign result_o.fan_drive_level = dim_lvl_d;
  assign result_o.heat_now        = heat_d;
  assign result_o.fan_now         = fan_d;
  assign result_o.fan_auto_raised = raised_d;

endmodule

/* hw/rtl/heater_fan_time_proportioning_control.sv */
// ----------------------------------------------------------------------------
// Heater and fan time-proportioning control
// Accepts slice ticks and commands, keeps the heat and fan levels with their
// interlocks and drives the heater relay in proportioning phases.
// ----------------------------------------------------------------------------
// Registers: an input register, then a result register. Throughput: one word
// per cycle unless result_o stalls; the result of a word is computed as it leaves
// the input register, in one pass of the core, so words follow back to back.
// Reset: levels, heater phase, relay and dimmer clear to zero; the registers take
// their defaults (2000 ms cycle, heating fan minimum 50).
module heater_fan_time_proportioning_control #(
  parameter int unsigned SLICE_MS         = hftp_pkg::SliceMsDef,
  parameter int unsigned MAX_CYCLE_SLICES = hftp_pkg::MaxCycleSlicesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hftp_stream_if.sink                   item_i,
  hftp_stream_if.source                 result_o,
  input  logic                          cfg_we_i,
  input  logic [hftp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hftp_pkg::CfgDataW-1:0] cfg_data_i
);
  import hftp_pkg::*;

  cfg_t cfg_q;
  logic s1_valid_q;
  in_t  s1_item_q;
  logic out_valid_q;
  out_t out_word_q;
  out_t core_result;
  logic advance;
  logic step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ms        <= CycleMsRst;
      cfg_q.heat_floor       <= MinHeatLevelRst;
      cfg_q.fan_floor        <= MinFanLevelRst;
      cfg_q.min_fan_for_heat <= MinFanForHeatRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CYCLE_MS:     cfg_q.period_ms        <= cfg_data_i;
        REG_MIN_HEAT:     cfg_q.heat_floor       <= cfg_data_i[LevelW-1:0];
        REG_MIN_FAN:      cfg_q.fan_floor        <= cfg_data_i[LevelW-1:0];
        REG_MIN_FAN_HEAT: cfg_q.min_fan_for_heat <= cfg_data_i[LevelW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input register moves on whenever the result register is free or
  // its word is being taken.
  assign advance      = !out_valid_q || result_o.ready;
  assign step         = s1_valid_q && advance;
  assign item_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_item_q <= item_i.payload;
    end
    if (step) begin
      out_word_q <= core_result;
    end
  end

  hftp_core #(
    .SLICE_MS         (SLICE_MS),
    .MAX_CYCLE_SLICES (MAX_CYCLE_SLICES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .result_o (core_result)
  );

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_word_q;

  a_step_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("word left the input register without a result");

  a_stalled_input_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input register lost a word while the result side stalled");

  a_heat_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_word_q.heat_now <= LevelW'(FullLevel)))
    else $error("heat level above full scale");

  a_raise_is_accepted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.fan_auto_raised) |->
      ((out_word_q.status == ST_OK) && out_word_q.fan_power))
    else $error("fan raise reported on a refused or dimmer-off result");

endmodule

/* tb/sv/tb_heater_fan_time_proportioning_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heater and fan time-proportioning control testbench
// Drives slice ticks and commands through the word stream and predicts every
// readout with a cycle-free model of the levels, interlocks and relay phases.
// It covers directed corner cases, randomised traffic under several register
// settings and idle/stall mixes, and a long output hold that fills the block.
// ----------------------------------------------------------------------------
module tb_heater_fan_time_proportioning_control;
  import hftp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;

  // Operation codes that the block must ignore.
  localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {
    HP_IDLE = 2'd0,
    HP_ON   = 2'd1,
    HP_OFF  = 2'd2
  } heater_phase_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  hftp_stream_if #(.T(in_t))  item_if ();
  hftp_stream_if #(.T(out_t)) result_if ();

  heater_fan_time_proportioning_control dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Register copies held by the controller model.
  logic [CycleMsW-1:0] lim_period_ms     = CycleMsRst;
  logic [LevelW-1:0]   lim_min_heat      = MinHeatLevelRst;
  logic [LevelW-1:0]   lim_min_fan       = MinFanLevelRst;
  logic [LevelW-1:0]   lim_min_fan_heat  = MinFanForHeatRst;

  // Controller state.
  logic [LevelW-1:0] heat_pct    = '0;
  logic [LevelW-1:0] fan_pct     = '0;
  logic [LevelW-1:0] sampled_pct = '0;
  logic [LevelW-1:0] dimmer_pct  = '0;
  heater_phase_e     phase       = HP_IDLE;
  int unsigned       slices_left = 0;
  logic              relay_on    = 1'b0;
  logic              dimmer_en   = 1'b0;

  out_t readout_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  logic        hold_taken     = 1'b0;
  int unsigned cycle_count    = 0;
  int unsigned words_accepted = 0;
  int unsigned readouts_seen  = 0;
  int unsigned settings_count = 0;
  int unsigned errors         = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Controller model
  // --------------------------------------------------------------------------
  function automatic int unsigned span_slices(logic [LevelW-1:0] pct);
    int unsigned ms;
    int unsigned n;
    ms = (32'(lim_period_ms) * 32'(pct)) / FullLevel;
    n  = (ms + SliceMsDef - 1) / SliceMsDef;
    if (n > MaxCycleSlicesDef) n = MaxCycleSlicesDef;
    return n;
  endfunction

  // A phase of zero slices hands over to the other one; if both are empty the
  // off phase is held for one slice and the relay is left alone.
  function automatic void open_phase(heater_phase_e ph);
    int unsigned n;
    for (int k = 0; k < 2; k++) begin
      sampled_pct = heat_pct;
      n = (ph == HP_ON) ? span_slices(sampled_pct)
                        : span_slices(LevelW'(FullLevel) - sampled_pct);
      if (n > 0) begin
        relay_on    = (ph == HP_ON);
        phase       = ph;
        slices_left = n;
        return;
      end
      ph = (ph == HP_ON) ? HP_OFF : HP_ON;
    end
    phase       = HP_OFF;
    slices_left = 1;
  endfunction

  function automatic status_e try_fan(logic [ValueW-1:0] pct);
    if (pct > FullLevel) return ST_ABOVE_MAX;
    if (heat_pct != 0 && pct < lim_min_fan_heat) return ST_FAN_LOW;
    if (pct < lim_min_fan) return ST_BELOW_MIN;
    fan_pct = pct[LevelW-1:0];
    if (pct == 0) begin
      dimmer_en = 1'b0;
    end else begin
      dimmer_en  = 1'b1;
      dimmer_pct = pct[LevelW-1:0];
    end
    return ST_OK;
  endfunction

  function automatic out_t advance_controller(in_t w);
    out_t    r;
    status_e st;
    logic    raised;
    st     = ST_OK;
    raised = 1'b0;
    case (w.operation)
      OP_TICK: begin
        if (phase != HP_IDLE) begin
          if (slices_left > 0) slices_left--;
          if (slices_left == 0 || heat_pct != sampled_pct)
            open_phase((phase == HP_ON) ? HP_OFF : HP_ON);
        end
      end
      OP_SET_HEAT: begin
        if (w.value > FullLevel) begin
          st = ST_ABOVE_MAX;
        end else if (w.value < lim_min_heat) begin
          st = ST_BELOW_MIN;
        end else begin
          // Heat is set even when the fan cannot be raised to its heating minimum.
          if (w.value != 0 && fan_pct < lim_min_fan_heat) begin
            if (try_fan(ValueW'(lim_min_fan_heat)) == ST_OK) raised = 1'b1;
          end
          heat_pct = w.value[LevelW-1:0];
          if (phase == HP_IDLE) open_phase(HP_ON);
        end
      end
      OP_SET_FAN: begin
        st = try_fan(w.value);
      end
      OP_START_ROAST: begin
        heat_pct = '0;
        fan_pct  = '0;
      end
      OP_START_COOL: begin
        heat_pct   = '0;
        fan_pct    = LevelW'(FullLevel);
        dimmer_pct = LevelW'(FullLevel);
      end
      OP_STOP: begin
        heat_pct   = '0;
        fan_pct    = '0;
        relay_on   = 1'b0;
        dimmer_en  = 1'b0;
        dimmer_pct = '0;
      end
      default: ;
    endcase
    r.status          = st;
    r.heater_drive    = relay_on;
    r.fan_power       = dimmer_en;
    r.fan_drive_level = dimmer_pct;
    r.heat_now        = heat_pct;
    r.fan_now         = fan_pct;
    r.fan_auto_raised = raised;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors, output ready and run limit
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && item_if.valid && item_if.ready) begin
      readout_q.push_back(advance_controller(item_if.payload));
      words_accepted++;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : readout_check
    out_t want;
    out_t got;
    if (rst_n && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (readout_q.size() == 0) begin
        $display("%0t ns: unexpected readout: expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = readout_q.pop_front();
        check_field("status", want.status, got.status);
        check_field("heater_drive", want.heater_drive, got.heater_drive);
        check_field("fan_power", want.fan_power, got.fan_power);
        check_field("fan_drive_level", want.fan_drive_level, got.fan_drive_level);
        check_field("heat_now", want.heat_now, got.heat_now);
        check_field("fan_now", want.fan_now, got.fan_now);
        check_field("fan_auto_raised", want.fan_auto_raised, got.fan_auto_raised);
        readouts_seen++;
      end
    end
  end

  // A requested hold keeps ready low for a counted stretch; otherwise ready
  // stalls at random at the current rate.
  always @(posedge clk) begin
    if (hold_request > 0 && !hold_taken) begin
      hold_left  = hold_request;
      hold_taken = 1'b1;
    end
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d readouts outstanding",
               cycle_count, readout_q.size());
      $display("heater_fan_time_proportioning_control test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Valid is left high on return so that a following word goes back to back.
  task automatic send_word(logic [OpW-1:0] op, logic [ValueW-1:0] val);
    in_t w;
    w.operation = op;
    w.value     = val;
    if ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= w;
    do @(posedge clk); while (!item_if.ready);
  endtask

  task automatic wait_for_readouts();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (readout_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [CycleMsW-1:0] period_ms, logic [LevelW-1:0] min_heat,
                                logic [LevelW-1:0] min_fan, logic [LevelW-1:0] min_fan_heat);
    wait_for_readouts();
    write_reg(REG_CYCLE_MS, period_ms);
    write_reg(REG_MIN_HEAT, CfgDataW'(min_heat));
    write_reg(REG_MIN_FAN, CfgDataW'(min_fan));
    write_reg(REG_MIN_FAN_HEAT, CfgDataW'(min_fan_heat));
    cfg_we           <= 1'b0;
    lim_period_ms    = period_ms;
    lim_min_heat     = min_heat;
    lim_min_fan      = min_fan;
    lim_min_fan_heat = min_fan_heat;
    settings_count++;
  endtask

  // Values cluster on the limits but still reach every 8-bit code.
  function automatic logic [ValueW-1:0] pick_value(logic [LevelW-1:0] near);
    case ($urandom_range(9))
      0:       return '0;
      1:       return ValueW'(FullLevel);
      2:       return ValueW'(near);
      3:       return ValueW'(near) - 1'b1;
      4:       return ValueW'(FullLevel + 1);
      5, 6:    return ValueW'($urandom_range(255));
      default: return ValueW'($urandom_range(FullLevel));
    endcase
  endfunction

  task automatic send_random_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_word(OP_TICK, ValueW'($urandom_range(255)));
    end else if (pick < 60) begin
      send_word(OP_SET_HEAT, pick_value(lim_min_heat));
    end else if (pick < 78) begin
      send_word(OP_SET_FAN, pick_value($urandom_range(1) ? lim_min_fan : lim_min_fan_heat));
    end else if (pick < 84) begin
      send_word(OP_START_ROAST, ValueW'($urandom_range(255)));
    end else if (pick < 90) begin
      send_word(OP_START_COOL, ValueW'($urandom_range(255)));
    end else if (pick < 96) begin
      send_word(OP_STOP, ValueW'($urandom_range(255)));
    end else begin
      send_word($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7, ValueW'($urandom_range(255)));
    end
  endtask

  task automatic run_segment(logic [CycleMsW-1:0] period_ms, logic [LevelW-1:0] min_heat,
                             logic [LevelW-1:0] min_fan, logic [LevelW-1:0] min_fan_heat,
                             int unsigned idle, int unsigned stall, int unsigned n);
    apply_settings(period_ms, min_heat, min_fan, min_fan_heat);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) send_random_word();
    wait_for_readouts();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_basic_commands();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_word(OP_TICK, 8'h00);          // heater not started yet
    send_word(OP_SET_FAN, 8'd0);
    send_word(OP_SET_HEAT, 8'd101);
    send_word(OP_SET_HEAT, 8'd255);
    send_word(OP_SET_HEAT, 8'd100);     // raises the idle fan and starts the relay
    send_word(OP_SET_FAN, 8'd49);
    send_word(OP_SET_FAN, 8'd100);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_SET_HEAT, 8'd30);
    send_word(OP_TICK, 8'h00);          // level change cuts the on phase short
    send_word(OP_START_COOL, 8'h00);
    send_word(OP_START_ROAST, 8'h00);
    send_word(OP_STOP, 8'h00);
    send_word(OP_SPARE_6, 8'hAA);
    send_word(OP_SPARE_7, 8'h55);
    send_word(OP_TICK, 8'h00);
    wait_for_readouts();
  endtask

  task automatic test_interlocks();
    apply_settings(16'd2000, 7'd30, 7'd60, 7'd40);
    send_word(OP_SET_HEAT, 8'd10);
    send_word(OP_SET_FAN, 8'd20);
    send_word(OP_SET_HEAT, 8'd50);      // raise to 40 refused by the fan minimum
    send_word(OP_SET_FAN, 8'd70);
    apply_settings(16'd2000, 7'd0, 7'd0, 7'd120);
    send_word(OP_STOP, 8'h00);
    send_word(OP_SET_HEAT, 8'd20);      // raise refused as above maximum
    send_word(OP_SET_FAN, 8'd0);
    wait_for_readouts();
  endtask

  task automatic test_tiny_cycle();
    // With no usable cycle length both phases round to zero slices.
    apply_settings(16'd0, 7'd0, 7'd0, 7'd0);
    send_word(OP_SET_HEAT, 8'd50);
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h00);
    apply_settings(16'd1, 7'd0, 7'd0, 7'd0);
    send_word(OP_SET_HEAT, 8'd100);
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h00);
    wait_for_readouts();
  endtask

  task automatic test_random_traffic();
    run_segment(16'd2000, 7'd0, 7'd0, 7'd50, 0, 0, 360);
    run_segment(16'd100, 7'd0, 7'd0, 7'd0, 56, 0, 360);
    run_segment(16'hFFFF, 7'd100, 7'd127, 7'd127, 0, 56, 150);
    run_segment(16'($urandom_range(100, 3000)), 7'($urandom_range(40)),
                7'($urandom_range(40)), 7'($urandom_range(100)), 14, 14, 360);
    run_segment(16'($urandom_range(100, 1500)), 7'($urandom_range(20)),
                7'($urandom_range(20)), 7'($urandom_range(60)), 0, 0, 360);
    run_segment(16'($urandom_range(100, 60000)), 7'($urandom_range(100)),
                7'($urandom_range(100)), 7'($urandom_range(100)), 56, 56, 200);
  endtask

  // The output is held off while words keep coming, so the block must fill
  // and push back on its input.
  task automatic test_output_hold();
    apply_settings(CycleMsRst, MinHeatLevelRst, MinFanLevelRst, MinFanForHeatRst);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = HOLD_CYCLES;
    repeat (80) send_random_word();
    wait_for_readouts();
  endtask

  initial begin
    rst_n             = 1'b0;
    item_if.valid     = 1'b0;
    item_if.payload   = '0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_CYCLE_MS;
    cfg_data          = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_commands();
    test_interlocks();
    test_tiny_cycle();
    test_random_traffic();
    test_output_hold();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d readouts for %0d words under %0d register settings,",
             readouts_seen, words_accepted, settings_count);
    $display("with idle and stall mixes and a %0d-cycle output hold; %0d mismatches.",
             HOLD_CYCLES, errors);
    if (errors == 0 && readout_q.size() == 0) begin
      $display("heater_fan_time_proportioning_control test passed");
    end else begin
      $display("heater_fan_time_proportioning_control test failed");
    end
    $finish;
  end

endmodule

/* heater_fan_time_proportioning_control.f */
hw/rtl/hftp_pkg.sv
hw/rtl/hftp_stream_if.sv
hw/rtl/hftp_phase_len.sv
hw/rtl/hftp_core.sv
hw/rtl/heater_fan_time_proportioning_control.sv
tb/sv/tb_heater_fan_time_proportioning_control.sv
